// ===== hw/rtl/swam_pkg.sv =====
package swam_pkg;

  // Letters arrive as indices 0..ALPHABET-1 in a fixed five-bit field.
  localparam int unsigned LETTER_W        = 5;
  localparam int unsigned FUNC_W          = 2;
  localparam int unsigned ALPHABET        = 26;
  localparam int unsigned MAX_PATTERN_DEF = 64;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_PATTERN = 2'd1,
    FUNC_TEXT    = 2'd2
  } func_e;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [LETTER_W-1:0] letter;
  } in_t;

  typedef struct packed {
    logic window_match;
    logic found;
    logic pattern_overflow;
  } out_t;

  // Update request for one histogram bank.
  typedef struct packed {
    logic                clr;
    logic                inc;
    logic [LETTER_W-1:0] inc_idx;
    logic                dec;
    logic [LETTER_W-1:0] dec_idx;
  } hist_ctl_t;

endpackage

// ===== hw/rtl/swam_ram.sv =====
module swam_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Read returns the old content on an address collision.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/swam_hist.sv =====
module swam_hist import swam_pkg::*; #(
  parameter int unsigned CNT_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  hist_ctl_t        ctl_i,
  output logic [CNT_W-1:0] cnt_next_o [ALPHABET]
);

  logic [CNT_W-1:0] cnt_q [ALPHABET];
  logic [CNT_W-1:0] cnt_d [ALPHABET];

  for (genvar k = 0; k < ALPHABET; k++) begin : g_lane
    logic inc_hit;
    logic dec_hit;

    assign inc_hit = ctl_i.inc && (ctl_i.inc_idx == LETTER_W'(k));
    // Drop a removal that would take the count below zero.
    assign dec_hit = ctl_i.dec && (ctl_i.dec_idx == LETTER_W'(k)) && (cnt_q[k] != '0);

    always_comb begin
      if (ctl_i.clr) begin
        cnt_d[k] = '0;
      end else begin
        cnt_d[k] = cnt_q[k] + CNT_W'(inc_hit) - CNT_W'(dec_hit);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q[k] <= '0;
      end else if (en_i) begin
        cnt_q[k] <= cnt_d[k];
      end
    end

    assign cnt_next_o[k] = cnt_d[k];
  end

endmodule

// ===== hw/rtl/sliding_window_anagram_match.sv =====
// Sliding-window anagram match. Each word carries a function code and a letter index
// (0..25, already mapped): clear resets all state, a pattern letter adds to the pattern
// histogram (letters beyond MAX_PATTERN are dropped and flag pattern_overflow), and a
// text letter enters a window whose length is the pattern length, pushing out the letter
// that entered pattern-length text letters earlier. Every accepted word yields exactly
// one result word: window_match says whether the current window is a permutation of the
// pattern, found is sticky since the last clear (and high while the pattern is empty).
// Out-of-range letters and the unused function code change nothing and do not match.
// The block takes one word per clock cycle while the result register is free or drained:
// a word sits in an input register, the histogram update and the 26-way compare run in
// one combinational pass, and the result lands in an output register that offers it.
// That single pass is set by the letter ring, a one-port-write, one-port-read memory whose
// registered read is prefetched from the next-state pointers. No clearing pass is needed
// after reset; the ring's read word is never used before its slot is written.
module sliding_window_anagram_match import swam_pkg::*; #(
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  // Counts go up to MAX_PATTERN; ring pointers span MAX_PATTERN slots.
  localparam int unsigned LW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned RW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // Input stage
  logic in_valid_q;
  in_t  in_q;
  logic proc;

  // Result stage
  logic out_valid_q;
  out_t out_q;

  // Scalar state
  logic [LW-1:0] plen_q, plen_d;
  logic [LW-1:0] fill_q, fill_d;
  logic [RW-1:0] pos_q, pos_d;
  logic          found_q, found_d;
  logic          ovf_q, ovf_d;

  // Histograms and letter ring
  hist_ctl_t     p_ctl, w_ctl;
  logic [LW-1:0] p_cnt_next [ALPHABET];
  logic [LW-1:0] w_cnt_next [ALPHABET];
  logic          ring_we;
  logic [RW-1:0] ring_raddr;
  logic [LW:0]   ring_raddr_wide;
  logic [LETTER_W-1:0] ring_rdata;
  logic          byp_q;
  logic [LETTER_W-1:0] byp_data_q;
  logic [LETTER_W-1:0] old_letter;

  logic letter_ok;
  logic is_clear;
  logic is_text;
  logic hist_eq;
  logic match;

  // Process the held word whenever the result register is free or being drained.
  assign proc       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  assign letter_ok = in_q.letter < LETTER_W'(ALPHABET);

  // The letter leaving the window: take the prefetched ring word, or the word written
  // in the same edge that the prefetch address pointed at.
  assign old_letter = byp_q ? byp_data_q : ring_rdata;

  always_comb begin
    plen_d   = plen_q;
    fill_d   = fill_q;
    pos_d    = pos_q;
    ovf_d    = ovf_q;
    ring_we  = 1'b0;
    is_clear = 1'b0;
    is_text  = 1'b0;

    p_ctl         = '0;
    p_ctl.inc_idx = in_q.letter;
    w_ctl         = '0;
    w_ctl.inc_idx = in_q.letter;
    w_ctl.dec_idx = old_letter;

    if (proc) begin
      unique case (in_q.func)
        FUNC_CLEAR: begin
          is_clear  = 1'b1;
          plen_d    = '0;
          fill_d    = '0;
          pos_d     = '0;
          ovf_d     = 1'b0;
          p_ctl.clr = 1'b1;
          w_ctl.clr = 1'b1;
        end
        FUNC_PATTERN: begin
          if (letter_ok) begin
            if (plen_q < LW'(MAX_PATTERN)) begin
              p_ctl.inc = 1'b1;
              plen_d    = plen_q + LW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
        FUNC_TEXT: begin
          if (letter_ok) begin
            is_text = 1'b1;
            // With an empty pattern the window stays empty; only the ring advances.
            if (plen_q != '0) begin
              if (fill_q < plen_q) begin
                fill_d = fill_q + LW'(1);
              end else begin
                w_ctl.dec = 1'b1;
              end
              w_ctl.inc = 1'b1;
            end
            ring_we = 1'b1;
            pos_d   = (pos_q == RW'(MAX_PATTERN - 1)) ? '0 : pos_q + RW'(1);
          end
        end
        default: begin
          // Unused code: hold everything.
        end
      endcase
    end
  end

  // Compare the updated histograms lane by lane.
  always_comb begin
    hist_eq = 1'b1;
    for (int k = 0; k < ALPHABET; k++) begin
      if (p_cnt_next[k] != w_cnt_next[k]) begin
        hist_eq = 1'b0;
      end
    end
  end

  assign match   = is_text && hist_eq;
  assign found_d = is_clear ? 1'b0 : (found_q || match);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q  <= '0;
      fill_q  <= '0;
      pos_q   <= '0;
      found_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (proc) begin
      plen_q  <= plen_d;
      fill_q  <= fill_d;
      pos_q   <= pos_d;
      found_q <= found_d;
      ovf_q   <= ovf_d;
    end
  end

  swam_hist #(
    .CNT_W (LW)
  ) u_pattern_hist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (proc),
    .ctl_i      (p_ctl),
    .cnt_next_o (p_cnt_next)
  );

  swam_hist #(
    .CNT_W (LW)
  ) u_window_hist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (proc),
    .ctl_i      (w_ctl),
    .cnt_next_o (w_cnt_next)
  );

  // Prefetch the slot that entered pattern-length text letters before the next
  // write position, using the next-state pointers, so the read word is ready for
  // whichever word is processed next.
  always_comb begin
    if ({1'b0, LW'(pos_d)} >= {1'b0, plen_d}) begin
      ring_raddr_wide = {1'b0, LW'(pos_d)} - {1'b0, plen_d};
    end else begin
      ring_raddr_wide = {1'b0, LW'(pos_d)} + (LW + 1)'(MAX_PATTERN) - {1'b0, plen_d};
    end
  end

  assign ring_raddr = ring_raddr_wide[RW-1:0];

  swam_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (MAX_PATTERN)
  ) u_letter_ring (
    .clk_i     (clk_i),
    .wr_en_i   (ring_we),
    .wr_addr_i (pos_q),
    .wr_data_i (in_q.letter),
    .rd_addr_i (ring_raddr),
    .rd_data_o (ring_rdata)
  );

  // Forward the written letter when the prefetch hits the slot being written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= ring_we && (pos_q == ring_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= in_q.letter;
  end

  // Result register: load on processing, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_q.window_match     <= match;
      out_q.found            <= found_d || (plen_d == '0);
      out_q.pattern_overflow <= ovf_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
